### rtl/core/exp_golomb_stream_decoder_unit_assert.svh
// Assertion helpers used by the checker file.
`ifndef EXP_GOLOMB_STREAM_DECODER_UNIT_ASSERT_SVH
`define EXP_GOLOMB_STREAM_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define EGD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("egd assertion failed");

// Next-cycle implication, disabled while reset is low.
`define EGD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("egd assertion failed");

// Checked on every rising clock edge, reset included.
`define EGD_ASSERT_ALWAYS(label, clk, expr) \
  label: assert property (@(posedge clk) (expr)) \
    else $error("egd assertion failed");

`endif

### rtl/core/egd_pkg.sv
package egd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned PART_W = 32;
  localparam int unsigned CODE_W = 33;
  localparam int unsigned CNT_W  = 6;

  // code_kind register values; the unused code decodes as unsigned
  localparam logic [1:0] KIND_UE    = 2'd0;
  localparam logic [1:0] KIND_SE    = 2'd1;
  localparam logic [1:0] KIND_FIXED = 2'd2;

  // register index, taken from paddr[2]
  localparam logic REG_CODE_KIND   = 1'b0;
  localparam logic REG_FIXED_WIDTH = 1'b1;

  localparam logic [CNT_W-1:0] FIXED_WIDTH_RST = 6'd8;
  localparam logic [CNT_W-1:0] FIXED_WIDTH_MAX = 6'd32;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              restart;
  } item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [CNT_W-1:0] width;
  } dec_cfg_t;

  typedef struct packed {
    logic signed [CODE_W-1:0] value;
    logic                     err;
    logic                     last;
  } result_t;

endpackage

### rtl/core/exp_golomb_stream_decoder_unit.sv
// Exp-Golomb / fixed-width bitstream decoder.
// Slave stream: one beat carries one stream byte (tdata), decoded MSB first;
//   tuser set discards any partially collected code before this byte.
// Master stream: one beat per decoded code. tdata holds the 33-bit value
//   (two's complement for the signed kind), tuser flags a leading-zero
//   overflow (value 0), tlast marks the final code produced by a byte.
//   A byte that completes no code produces no beat.
// APB port: code_kind at 0x0, fixed_width at 0x4; pready is tied high.
//   Any write clears the partial code. Write only while the block is idle.
// Throughput: one cycle per bit in the bit-serial back end unless a master
//   stall holds it; a two-beat input queue keeps the slave side accepting
//   meanwhile. Output path: each code is held until it is known whether
//   another one follows in the byte, then moves to the output register
//   once the next code or its byte's final bit is decoded.
// Reset: code_kind unsigned, fixed_width 8, no partial code, queues empty.
// Master stall: the output register and the held code hold; the decoder
//   pauses on the next bit that needs to move a code, and the input queue
//   fills, then deasserts s_axis_tready.
module exp_golomb_stream_decoder_unit #(
  parameter int unsigned MAX_LEADING_ZEROS = 31
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
  input  logic        s_axis_tuser,   // [0] restart
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [32:0] code_value, [39:33] zero
  output logic        m_axis_tuser,   // [0] code_error
  output logic        m_axis_tlast,   // last_of_byte
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import egd_pkg::*;

  logic             cfg_wr;
  logic             reg_idx;
  logic [1:0]       kind_q;
  logic [CNT_W-1:0] width_q;
  dec_cfg_t         cfg;

  item_t   in_item, q_item;
  logic    q_valid, q_take;
  logic    res_valid;
  result_t res;

  // register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= KIND_UE;
      width_q <= FIXED_WIDTH_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_CODE_KIND:   kind_q  <= pwdata[1:0];
        REG_FIXED_WIDTH: width_q <= pwdata[CNT_W-1:0];
        default:         kind_q  <= kind_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CODE_KIND:   prdata = {30'd0, kind_q};
      REG_FIXED_WIDTH: prdata = {26'd0, width_q};
      default:         prdata = '0;
    endcase
  end

  assign cfg.kind  = kind_q;
  assign cfg.width = width_q;

  // front: input queue
  assign in_item.data    = s_axis_tdata;
  assign in_item.restart = s_axis_tuser;

  egd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_item_i  (in_item),
    .s_ready_o (s_axis_tready),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_take_i  (q_take)
  );

  // back: bit-serial decoder with output register
  egd_back #(
    .MAX_LEADING_ZEROS (MAX_LEADING_ZEROS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .clear_i      (cfg_wr),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .item_take_o  (q_take),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_ready_i  (m_axis_tready)
  );

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {7'd0, res.value};
  assign m_axis_tuser  = res.err;
  assign m_axis_tlast  = res.last;

endmodule

### rtl/core/egd_front.sv
module egd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  input  egd_pkg::item_t s_item_i,
  output logic          s_ready_o,
  output logic          q_valid_o,
  output egd_pkg::item_t q_item_o,
  input  logic          q_take_i
);
  import egd_pkg::*;

  // two-entry queue between stream input and bit-serial decoder
  item_t      slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign s_ready_o = (count_q != 2'd2);
  assign q_valid_o = (count_q != 2'd0);
  assign q_item_o  = slot_q[rd_ptr_q];
  assign push      = s_valid_i && s_ready_o;
  assign pop       = q_take_i && q_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= s_item_i;
  end

endmodule

### rtl/core/egd_back.sv
module egd_back #(
  parameter int unsigned MAX_LEADING_ZEROS = 31
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  egd_pkg::dec_cfg_t cfg_i,
  input  logic             clear_i,
  input  logic             item_valid_i,
  input  egd_pkg::item_t   item_i,
  output logic             item_take_o,
  output logic             res_valid_o,
  output egd_pkg::result_t res_o,
  input  logic             res_ready_i
);
  import egd_pkg::*;

  localparam logic [CNT_W-1:0] ZR_LIMIT = CNT_W'(MAX_LEADING_ZEROS);

  // byte being shifted out, MSB first
  logic              busy_q;
  logic [BYTE_W-1:0] byte_q;
  logic              restart_q;
  logic [2:0]        bit_idx_q;

  // code state
  logic              reading_q, reading_d;
  logic [CNT_W-1:0]  zrun_q, zrun_d;
  logic [CNT_W-1:0]  btr_q, btr_d;
  logic [PART_W-1:0] part_q, part_d;

  // one result held back until we know whether it ends the byte
  logic              pend_valid_q, pend_last_q, pend_err_q;
  logic [CODE_W-1:0] pend_val_q;

  logic              out_valid_q;
  result_t           out_q;

  logic              first_bit, final_bit, drop, b;
  logic              c_reading;
  logic [CNT_W-1:0]  c_zrun, c_btr, btr_dec, zr_inc, eff_w;
  logic [PART_W-1:0] c_part, shifted;
  logic [CODE_W-1:0] val_fix, val_ue, val_se_pos, val_se_neg, fin_val;
  logic              emit, emit_err;
  logic [CODE_W-1:0] emit_val;
  logic              out_space, step, push, push_last;

  assign first_bit = (bit_idx_q == 3'd7);
  assign final_bit = (bit_idx_q == 3'd0);
  assign drop      = first_bit && restart_q;
  assign b         = byte_q[bit_idx_q];

  assign c_reading = drop ? 1'b0 : reading_q;
  assign c_zrun    = drop ? '0 : zrun_q;
  assign c_btr     = drop ? '0 : btr_q;
  assign c_part    = drop ? '0 : part_q;

  assign shifted = {c_part[PART_W-2:0], b};
  assign btr_dec = (c_btr != '0) ? c_btr - 6'd1 : '0;
  assign zr_inc  = c_zrun + 6'd1;

  always_comb begin
    if (cfg_i.width == '0)                 eff_w = 6'd1;
    else if (cfg_i.width > FIXED_WIDTH_MAX) eff_w = FIXED_WIDTH_MAX;
    else                                    eff_w = cfg_i.width;
  end

  // value of a completed code
  assign val_fix    = {1'b0, shifted};
  assign val_ue     = {1'b0, shifted} - 33'd1;
  assign val_se_pos = {2'b00, shifted[PART_W-1:1]};
  assign val_se_neg = 33'd0 - val_se_pos;

  always_comb begin
    if (cfg_i.kind == KIND_FIXED)  fin_val = val_fix;
    else if (shifted == '0)        fin_val = '0;
    else if (cfg_i.kind == KIND_SE) fin_val = shifted[0] ? val_se_neg : val_se_pos;
    else                           fin_val = val_ue;
  end

  // one bit of decode
  always_comb begin
    reading_d = c_reading;
    zrun_d    = c_zrun;
    btr_d     = c_btr;
    part_d    = c_part;
    emit      = 1'b0;
    emit_err  = 1'b0;
    emit_val  = '0;
    if (!c_reading) begin
      if (cfg_i.kind == KIND_FIXED) begin
        if (eff_w == 6'd1) begin
          emit      = 1'b1;
          emit_val  = {{(CODE_W-1){1'b0}}, b};
          part_d    = '0;
        end else begin
          part_d    = {{(PART_W-1){1'b0}}, b};
          btr_d     = eff_w - 6'd1;
          reading_d = 1'b1;
        end
      end else if (!b) begin
        if (zr_inc > ZR_LIMIT) begin
          emit     = 1'b1;
          emit_err = 1'b1;
          zrun_d   = '0;
          btr_d    = '0;
          part_d   = '0;
        end else begin
          zrun_d = zr_inc;
        end
      end else if (c_zrun == '0) begin
        // lone one: zero in both Exp-Golomb kinds, no sign bit
        emit   = 1'b1;
        part_d = '0;
        btr_d  = '0;
      end else begin
        part_d    = {{(PART_W-1){1'b0}}, 1'b1};
        btr_d     = c_zrun;
        reading_d = 1'b1;
      end
    end else begin
      part_d = shifted;
      btr_d  = btr_dec;
      if (btr_dec == '0) begin
        emit      = 1'b1;
        emit_val  = fin_val;
        reading_d = 1'b0;
        zrun_d    = '0;
        btr_d     = '0;
        part_d    = '0;
      end
    end
  end

  // handshake between bit stepping, held result and output register
  assign out_space = !out_valid_q || res_ready_i;
  assign step      = busy_q && (!pend_valid_q || out_space ||
                                (!pend_last_q && !emit && !final_bit));
  assign push      = pend_valid_q && out_space &&
                     (pend_last_q || (busy_q && (emit || final_bit)));
  assign push_last = pend_last_q || (final_bit && !emit);
  assign item_take_o = item_valid_i && (!busy_q || (step && final_bit));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      bit_idx_q    <= 3'd7;
      reading_q    <= 1'b0;
      zrun_q       <= '0;
      btr_q        <= '0;
      part_q       <= '0;
      pend_valid_q <= 1'b0;
      pend_last_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (item_take_o) begin
        busy_q    <= 1'b1;
        bit_idx_q <= 3'd7;
      end else if (step) begin
        bit_idx_q <= bit_idx_q - 3'd1;
        if (final_bit) busy_q <= 1'b0;
      end

      if (clear_i) begin
        reading_q <= 1'b0;
        zrun_q    <= '0;
        btr_q     <= '0;
        part_q    <= '0;
      end else if (step) begin
        reading_q <= reading_d;
        zrun_q    <= zrun_d;
        btr_q     <= btr_d;
        part_q    <= part_d;
      end

      if (step && emit) begin
        pend_valid_q <= 1'b1;
        pend_last_q  <= final_bit;
      end else if (push) begin
        pend_valid_q <= 1'b0;
      end

      if (push)             out_valid_q <= 1'b1;
      else if (res_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take_o) begin
      byte_q    <= item_i.data;
      restart_q <= item_i.restart;
    end
    if (step && emit) begin
      pend_val_q <= emit_val;
      pend_err_q <= emit_err;
    end
    if (push) begin
      out_q.value <= $signed(pend_val_q);
      out_q.err   <= pend_err_q;
      out_q.last  <= push_last;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

### rtl/core/egd_checker.sv
`include "exp_golomb_stream_decoder_unit_assert.svh"

module egd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // stalled result beat holds
  `EGD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

  // overflow beats carry a zero value
  `EGD_ASSERT_IMP(a_err_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tdata[32:0] == 33'd0)

  // padding above the value stays clear
  `EGD_ASSERT_IMP(a_pad_zero, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[39:33] == 7'd0)

  // no result beat while in reset
  `EGD_ASSERT_ALWAYS(a_rst_quiet, clk_i, rst_ni || !m_axis_tvalid)

endmodule

bind exp_golomb_stream_decoder_unit egd_checker u_egd_checker (.*);

### tb/tb_exp_golomb_stream_decoder_unit.sv
module tb_exp_golomb_stream_decoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import egd_pkg::*;

  localparam int MAX_LZ       = 31;
  localparam int RAND_ITEMS   = 230;
  // bytes that complete no code can still sit in the input queue and the
  // bit-serial back end after the last result: 3 bytes plus slack
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT        = 300000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] stream_byte
  logic        s_axis_tuser;   // [0] restart
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // [32:0] code_value, [39:33] zero
  logic        m_axis_tuser;   // [0] code_error
  logic        m_axis_tlast;   // last_of_byte
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  exp_golomb_stream_decoder_unit #(
    .MAX_LEADING_ZEROS(MAX_LZ)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // stream bytes waiting to be sent, and decoded codes waiting to arrive
  item_t   byte_q [$];
  result_t code_q [$];

  // decoder copy: configuration and partial-code state
  logic [1:0]       cfg_kind;
  logic [CNT_W-1:0] cfg_width;
  logic             dec_reading;
  logic [CNT_W-1:0] dec_zeros;
  logic [CNT_W-1:0] dec_left;
  logic [PART_W-1:0] dec_bits;

  int      fail_cnt;
  int      cycle_cnt;
  logic    beat_taken;
  int      burst_left;
  int      gap_left;
  logic    drain_hold;
  logic    snd;
  int      rdy_left;
  int      rdy_mode;
  logic    rdy;
  result_t want;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic clear_code();
    dec_reading = 1'b0;
    dec_zeros   = '0;
    dec_left    = '0;
    dec_bits    = '0;
  endtask

  function automatic logic [CNT_W-1:0] fixed_bits();
    if (cfg_width == '0) return 6'd1;
    if (cfg_width > FIXED_WIDTH_MAX) return FIXED_WIDTH_MAX;
    return cfg_width;
  endfunction

  // value of the collected bits; bits include the marker one for Exp-Golomb
  function automatic logic [CODE_W-1:0] code_val();
    logic [CODE_W-1:0] v;
    logic [CODE_W-1:0] k;
    v = {1'b0, dec_bits};
    if (cfg_kind == KIND_FIXED) return v;
    if (v == '0) return '0;
    k = v - 33'd1;
    if (cfg_kind == KIND_SE) begin
      if (k[0]) return (k + 33'd1) >> 1;
      return -(k >> 1);
    end
    return k;
  endfunction

  // walk one byte MSB first, queue every code it completes
  task automatic decode_byte(input item_t it);
    result_t          res [8];
    int               n;
    logic             b;
    logic             got;
    logic             ge;
    logic [CODE_W-1:0] gv;
    logic [CNT_W-1:0] w;
    n = 0;
    if (it.restart) clear_code();
    for (int i = 7; i >= 0; i--) begin
      b   = it.data[i];
      got = 1'b0;
      ge  = 1'b0;
      gv  = '0;
      if (!dec_reading) begin
        if (cfg_kind == KIND_FIXED) begin
          w = fixed_bits();
          dec_bits = {31'd0, b};
          if (w == 6'd1) begin
            got = 1'b1;
            gv  = code_val();
          end else begin
            dec_left    = w - 6'd1;
            dec_reading = 1'b1;
          end
        end else if (!b) begin
          dec_zeros = dec_zeros + 6'd1;
          if (dec_zeros > MAX_LZ) begin
            got = 1'b1;
            ge  = 1'b1;
          end
        end else if (dec_zeros == '0) begin
          // lone one: zero in both kinds, no sign bit follows
          got = 1'b1;
        end else begin
          dec_bits    = 32'd1;
          dec_left    = dec_zeros;
          dec_reading = 1'b1;
        end
      end else begin
        dec_bits = {dec_bits[PART_W-2:0], b};
        if (dec_left != '0) dec_left = dec_left - 6'd1;
        if (dec_left == '0) begin
          got = 1'b1;
          gv  = code_val();
        end
      end
      if (got) begin
        res[n].value = gv;
        res[n].err   = ge;
        res[n].last  = 1'b0;
        n++;
        clear_code();
      end
    end
    for (int k = 0; k < n; k++) begin
      if (k == n - 1) res[k].last = 1'b1;
      code_q.insert(code_q.size(), res[k]);
    end
  endtask

  // output check first, then prediction of the byte taken at this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (code_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("unexpected code beat: tdata %h tuser %b tlast %b",
                     m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end else begin
          want = code_q.pop_front();
          if (m_axis_tdata !== {7'd0, want.value} || m_axis_tuser !== want.err ||
              m_axis_tlast !== want.last) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("code mismatch: exp value %h err %b last %b, got tdata %h tuser %b tlast %b",
                       want.value, want.err, want.last,
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        decode_byte(byte_q.pop_front());
        beat_taken = 1'b1;
      end
    end
  end

  // sender: bursts with random gaps; a beat once offered stays until taken
  always @(negedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid && !beat_taken)) begin
      if (beat_taken) begin
        beat_taken = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          // now and then hold off until every pending code is out
          drain_hold = ($urandom_range(0, 29) == 0);
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                   : $urandom_range(1, 10);
        end
      end
      if (drain_hold && code_q.size() == 0) drain_hold = 1'b0;
      snd = 1'b0;
      if (gap_left > 0) gap_left--;
      else if (!drain_hold && byte_q.size() > 0) snd = 1'b1;
      if (snd) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= byte_q[0].data;
        s_axis_tuser  <= byte_q[0].restart;
      end else begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tuser  <= 1'b0;
      end
    end
  end

  // receiver: stall pattern switches mode when its random run length runs out
  always @(negedge clk_i) begin
    if (rdy_left == 0) begin
      rdy_mode = $urandom_range(0, 3);
      rdy_left = $urandom_range(8, 64);
    end
    rdy_left--;
    case (rdy_mode)
      0: rdy = 1'b1;
      1: rdy = $urandom_range(0, 1);
      2: rdy = ($urandom_range(0, 4) == 0);
      default: rdy = (rdy_left % 4 != 0);
    endcase
    m_axis_tready <= rdy;
  end

  task automatic reg_write(input logic idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_CODE_KIND) cfg_kind = val[1:0];
    else cfg_width = val[CNT_W-1:0];
    clear_code();
  endtask

  task automatic push_byte(input logic [7:0] data, input logic restart);
    item_t it;
    it.data    = data;
    it.restart = restart;
    byte_q.insert(byte_q.size(), it);
  endtask

  task automatic wait_idle();
    while (byte_q.size() != 0 || code_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // mostly well-formed code streams with random content; some restarts
  // cut codes short and some bytes are plain noise
  task automatic gen_stream(input int n_items);
    bit   bits [$];
    int   made;
    int   r;
    int   z;
    bit   ones;
    item_t it;
    made = 0;
    while (made < n_items) begin
      if (bits.size() < 8) begin
        if (cfg_kind == KIND_FIXED) begin
          r = $urandom_range(0, 9);
          for (int i = 0; i < 8; i++)
            bits.insert(bits.size(),
                        r == 0 ? 1'b1 : r == 1 ? 1'b0 : 1'($urandom_range(0, 1)));
        end else begin
          r = $urandom_range(0, 99);
          if (r < 55) z = $urandom_range(0, 3);
          else if (r < 85) z = $urandom_range(4, 12);
          else if (r < 97) z = $urandom_range(13, MAX_LZ);
          else z = MAX_LZ + 1;
          for (int i = 0; i < z; i++) bits.insert(bits.size(), 1'b0);
          if (z <= MAX_LZ) begin
            ones = (z > 12) && ($urandom_range(0, 2) == 0);
            bits.insert(bits.size(), 1'b1);
            for (int i = 0; i < z; i++)
              bits.insert(bits.size(), ones ? 1'b1 : 1'($urandom_range(0, 1)));
          end
        end
      end else begin
        for (int i = 7; i >= 0; i--) it.data[i] = bits.pop_front();
        if ($urandom_range(0, 9) == 0) it.data = 8'($urandom_range(0, 255));
        it.restart = ($urandom_range(0, 19) == 0);
        byte_q.insert(byte_q.size(), it);
        made++;
      end
    end
  endtask

  function automatic logic [31:0] pick_kind();
    int r;
    r = $urandom_range(0, 19);
    if (r < 6) return {30'd0, KIND_UE};
    if (r < 13) return {30'd0, KIND_SE};
    if (r < 19) return {30'd0, KIND_FIXED};
    return 32'd3;  // unused code, decodes as unsigned
  endfunction

  function automatic logic [31:0] pick_width();
    case ($urandom_range(0, 9))
      0: return 32'd1;
      1: return 32'd32;
      2: return 32'd0;
      3: return $urandom_range(33, 63);
      4: return 32'd8;
      default: return $urandom_range(1, 31);
    endcase
  endfunction

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : main_seq
    int rand_items;
    int n;
    rst_ni        = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    fail_cnt      = 0;
    beat_taken    = 1'b0;
    burst_left    = 4;
    gap_left      = 0;
    drain_hold    = 1'b0;
    rdy_left      = 0;
    rdy_mode      = 0;
    cfg_kind      = KIND_UE;
    cfg_width     = FIXED_WIDTH_RST;
    clear_code();
    // clean falling reset edge ahead of the first clock
    #1;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // unsigned, reset settings: eight lone ones, zero-run overflow,
    // longest legal code, restart dropping a partial run
    push_byte(8'hFF, 1'b0);
    repeat (4) push_byte(8'h00, 1'b0);
    repeat (3) push_byte(8'h00, 1'b0);
    push_byte(8'h01, 1'b0);
    repeat (4) push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h20, 1'b1);
    wait_idle();

    // signed: positive, negative, lone one, carry over
    reg_write(REG_CODE_KIND, {30'd0, KIND_SE});
    push_byte(8'h5C, 1'b0);
    push_byte(8'h27, 1'b0);
    wait_idle();

    // fixed width: one-bit fields, clamp above 32 with all ones, zero as one
    reg_write(REG_CODE_KIND, {30'd0, KIND_FIXED});
    reg_write(REG_FIXED_WIDTH, 32'd1);
    push_byte(8'hA5, 1'b0);
    wait_idle();
    reg_write(REG_FIXED_WIDTH, 32'd63);
    repeat (4) push_byte(8'hFF, 1'b0);
    wait_idle();
    reg_write(REG_FIXED_WIDTH, 32'd0);
    push_byte(8'h3C, 1'b0);
    wait_idle();

    // unused kind code
    reg_write(REG_CODE_KIND, 32'd3);
    push_byte(8'h5C, 1'b0);
    wait_idle();

    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      if ($urandom_range(0, 4) != 0) reg_write(REG_CODE_KIND, pick_kind());
      if ($urandom_range(0, 1) == 0) reg_write(REG_FIXED_WIDTH, pick_width());
      n = $urandom_range(12, 36);
      gen_stream(n);
      rand_items += n;
      wait_idle();
    end

    if (fail_cnt == 0 && code_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
